@@ rtl/core/incremental_disc_weighted_average_assert.svh @@
// Assertion macros for the disc weighted average core.
// Used by the top level; compiles to nothing when SYNTHESIS is defined.
`ifndef INCREMENTAL_DISC_WEIGHTED_AVERAGE_ASSERT_SVH
`define INCREMENTAL_DISC_WEIGHTED_AVERAGE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define IDWA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("idwa assertion failed");
// Next-cycle implication.
`define IDWA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("idwa assertion failed");
`else
`define IDWA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IDWA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/idwa_pkg.sv @@
// Shared widths, opcodes, constants and unit status type for the
// disc weighted average core. No dependencies.
package idwa_pkg;

	localparam int IDX_W     = 12;
	localparam int VAL_W     = 24;
	localparam int AREA_W    = 16;
	localparam int PROD_W    = VAL_W + AREA_W + 1;
	localparam int WSUM_W    = 53;
	localparam int ASUM_W    = 29;
	localparam int DIV_CNT_W = 6;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_LOAD   = 2'd0;
	localparam opcode_t OP_START  = 2'd1;
	localparam opcode_t OP_ADD    = 2'd2;
	localparam opcode_t OP_REMOVE = 2'd3;

	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// Status of a multi-cycle unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

@@ rtl/core/idwa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module idwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/idwa_slot.sv @@
// Two-lane iterative reduction of point indexes modulo MAX_POINTS.
// Depends on idwa_pkg.
module idwa_slot #(
	parameter int MAX_POINTS = 4096,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [idwa_pkg::IDX_W-1:0]  index_a,
	input  logic [idwa_pkg::IDX_W-1:0]  index_b,
	output logic [AW-1:0]               slot_a,
	output logic [AW-1:0]               slot_b,
	output idwa_pkg::unit_sts_t         sts
);

	localparam int IW    = idwa_pkg::IDX_W;
	localparam int SPAN  = 1 << IW;
	localparam int STEPS = (MAX_POINTS >= SPAN) ? 0 :
		$clog2((SPAN + MAX_POINTS - 1) / MAX_POINTS);
	localparam int CNT_W = (STEPS > 0) ? $clog2(STEPS + 1) : 1;
	localparam logic [IW:0] MOD_V = (MAX_POINTS >= SPAN) ? '0 : (IW+1)'(MAX_POINTS);

	logic [IW-1:0]    xa_q, xb_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [CNT_W-1:0] shift;
	logic [IW:0]      mod_sh;
	logic             fit_a, fit_b;

	assign shift  = CNT_W'(cnt_q - 1'b1);
	assign mod_sh = MOD_V << shift;
	assign fit_a  = {1'b0, xa_q} >= mod_sh;
	assign fit_b  = {1'b0, xb_q} >= mod_sh;

	// Subtract the shifted modulus from each lane, largest multiple first.
	always_ff @(posedge clk) begin
		if (start) begin
			xa_q <= index_a;
			xb_q <= index_b;
		end else if (busy_q) begin
			if (fit_a) begin
				xa_q <= xa_q - mod_sh[IW-1:0];
			end
			if (fit_b) begin
				xb_q <= xb_q - mod_sh[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(STEPS);
				busy_q <= (STEPS > 0);
				done_q <= (STEPS == 0);
			end else if (busy_q) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign slot_a   = AW'(xa_q);
	assign slot_b   = AW'(xb_q);
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ rtl/core/idwa_div.sv @@
// Bit-serial restoring divider: signed weighted sum by positive area sum,
// quotient truncated toward zero and saturated to Q12.12. Depends on idwa_pkg.
module idwa_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [idwa_pkg::WSUM_W-1:0] dividend,
	input  logic [idwa_pkg::ASUM_W-1:0]        divisor,
	output logic signed [idwa_pkg::VAL_W-1:0]  quotient,
	output idwa_pkg::unit_sts_t                sts
);

	localparam int NW = idwa_pkg::WSUM_W;
	localparam int DW = idwa_pkg::ASUM_W;
	localparam int QW = idwa_pkg::VAL_W;
	localparam int CW = idwa_pkg::DIV_CNT_W;

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q, den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial, diff;
	logic          fits;
	logic          pos_sat, neg_sat;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= dividend[NW-1] ? NW'(~dividend + 1'b1) : dividend;
			neg_q <= dividend[NW-1];
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= CW'(cnt_q - 1'b1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Clamp the magnitude to the Q12.12 range, then apply the sign.
	assign pos_sat = |num_q[NW-1:QW-1];
	assign neg_sat = (|num_q[NW-1:QW]) || (num_q[QW-1] && (|num_q[QW-2:0]));

	always_comb begin
		if (neg_q) begin
			quotient = neg_sat ? idwa_pkg::VAL_MIN : QW'(~num_q[QW-1:0] + 1'b1);
		end else begin
			quotient = pos_sat ? idwa_pkg::VAL_MAX : num_q[QW-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ rtl/core/incremental_disc_weighted_average.sv @@
// Top level of the disc weighted average core; uses idwa_pkg, idwa_ram,
// idwa_slot, idwa_div and the assertion macro header.
//
// Input channel (item_valid / item_stall): one transfer per item. Opcode 0
// loads a point's Q12.12 value and area; opcode 1 opens a record (current
// and reference point); opcodes 2 and 3 add or remove a member. An item
// with end_of_record set (not a load) closes the record and yields one
// result transfer on result_valid / result_stall: the current index and the
// area-weighted average, truncated and saturated, or 0 without area.
// Steps: a load or a record start passes the index reduction (no steps
// when MAX_POINTS >= 4096); a member also reads the point and applies
// its product. Closing a record reads and stores the sums and, with area,
// runs the bit-serial divider, one quotient bit per cycle. Indexes wrap
// modulo MAX_POINTS through a restoring reduction, one step per cycle.
// Reset clears the sequencer, the open record and the running sums; point
// and sum memories hold nothing until written. A stalled result stays in
// the output register while the next item is taken; a further record end
// waits until that register frees.
`include "incremental_disc_weighted_average_assert.svh"
module incremental_disc_weighted_average #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [1:0]                         opcode,
	input  logic [idwa_pkg::IDX_W-1:0]         point_index,
	input  logic [idwa_pkg::IDX_W-1:0]         reference_index,
	input  logic signed [idwa_pkg::VAL_W-1:0]  sample_value,
	input  logic [idwa_pkg::AREA_W-1:0]        cell_area,
	input  logic                               end_of_record,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [idwa_pkg::IDX_W-1:0]         result_index,
	output logic signed [idwa_pkg::VAL_W-1:0]  smoothed_value
);

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int IW    = idwa_pkg::IDX_W;
	localparam int VW    = idwa_pkg::VAL_W;
	localparam int ARW   = idwa_pkg::AREA_W;
	localparam int PW    = idwa_pkg::PROD_W;
	localparam int WW    = idwa_pkg::WSUM_W;
	localparam int SW    = idwa_pkg::ASUM_W;
	localparam int VA_W  = VW + ARW;
	localparam int SUM_W = WW + SW;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_FRD  = 3'd4;
	localparam logic [2:0] ST_FSUM = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_LOAD = 3'd7;

	logic [2:0] state_q, state_d;

	// Latched input item.
	idwa_pkg::opcode_t op_q;
	logic [IW-1:0]     pidx_q;
	logic [VW-1:0]     val_q;
	logic [ARW-1:0]    area_in_q;
	logic              eor_q;

	// Open record and running sums.
	logic [IW-1:0] open_current_q;
	logic [AW-1:0] cur_slot_q, ref_slot_q;
	logic [WW-1:0] run_w_q;
	logic [SW-1:0] run_a_q;

	// Member product path.
	logic signed [PW-1:0] prod_q;
	logic [ARW-1:0]       mem_area_q;

	// Result path.
	logic [VW-1:0] res_q;
	logic          result_valid_q;
	logic [IW-1:0] result_index_q;
	logic [VW-1:0] smoothed_q;

	logic item_accept, load_ok;

	// Unit hookup.
	logic                  slot_start;
	logic [AW-1:0]         slot_a, slot_b;
	idwa_pkg::unit_sts_t   slot_sts;
	logic                  div_start;
	logic signed [VW-1:0]  div_quot;
	idwa_pkg::unit_sts_t   div_sts;

	// Memory ports.
	logic            va_we, va_re;
	logic [AW-1:0]   va_raddr;
	logic [VA_W-1:0] va_rdata;
	logic            sum_we, sum_re;
	logic [SUM_W-1:0] sum_rdata;

	// Record close arithmetic.
	logic [WW-1:0]  fin_w;
	logic [SW-1:0]  fin_a;
	logic           use_ref, area_pos, div_go;
	logic [ARW-1:0] own_area;

	assign item_stall  = (state_q != ST_IDLE);
	assign item_accept = item_valid && !item_stall;
	assign load_ok     = !result_valid_q || !result_stall;

	idwa_slot #(.MAX_POINTS(MAX_POINTS)) u_slot (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (slot_start),
		.index_a (point_index),
		.index_b (reference_index),
		.slot_a  (slot_a),
		.slot_b  (slot_b),
		.sts     (slot_sts)
	);

	// Point store: value and area side by side.
	idwa_ram #(.WIDTH(VA_W), .DEPTH(MAX_POINTS)) u_va_ram (
		.clk   (clk),
		.we    (va_we),
		.waddr (slot_a),
		.wdata ({val_q, area_in_q}),
		.re    (va_re),
		.raddr (va_raddr),
		.rdata (va_rdata)
	);

	// Stored window sums: weighted sum above area sum.
	idwa_ram #(.WIDTH(SUM_W), .DEPTH(MAX_POINTS)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (cur_slot_q),
		.wdata ({fin_w, fin_a}),
		.re    (sum_re),
		.raddr (ref_slot_q),
		.rdata (sum_rdata)
	);

	idwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (fin_w),
		.divisor  (fin_a),
		.quotient (div_quot),
		.sts      (div_sts)
	);

	// Fold in the reference sums unless the record points at itself.
	assign use_ref  = (cur_slot_q != ref_slot_q);
	assign fin_w    = run_w_q + (use_ref ? sum_rdata[SUM_W-1:SW] : WW'(0));
	assign fin_a    = run_a_q + (use_ref ? sum_rdata[SW-1:0] : SW'(0));
	assign own_area = va_rdata[ARW-1:0];
	assign area_pos = !fin_a[SW-1] && (fin_a != '0);
	assign div_go   = area_pos && (own_area != '0);

	always_comb begin
		state_d    = state_q;
		slot_start = 1'b0;
		div_start  = 1'b0;
		va_we      = 1'b0;
		va_re      = 1'b0;
		va_raddr   = cur_slot_q;
		sum_we     = 1'b0;
		sum_re     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_accept) begin
					slot_start = 1'b1;
					state_d    = ST_RED;
				end
			end
			ST_RED: begin
				if (slot_sts.done) begin
					unique case (op_q) inside
						idwa_pkg::OP_LOAD: begin
							va_we   = 1'b1;
							state_d = ST_IDLE;
						end
						idwa_pkg::OP_START: begin
							state_d = eor_q ? ST_FRD : ST_IDLE;
						end
						idwa_pkg::OP_ADD, idwa_pkg::OP_REMOVE: begin
							va_re    = 1'b1;
							va_raddr = slot_a;
							state_d  = ST_MUL;
						end
					endcase
				end
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = eor_q ? ST_FRD : ST_IDLE;
			end
			ST_FRD: begin
				va_re   = 1'b1;
				sum_re  = 1'b1;
				state_d = ST_FSUM;
			end
			ST_FSUM: begin
				sum_we = 1'b1;
				if (div_go) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (load_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Payload registers: latch item, form product, hold result, load output.
	always_ff @(posedge clk) begin
		if (item_accept) begin
			op_q      <= opcode;
			pidx_q    <= point_index;
			val_q     <= sample_value;
			area_in_q <= cell_area;
			eor_q     <= end_of_record;
		end
		if (state_q == ST_MUL) begin
			prod_q     <= $signed(va_rdata[VA_W-1:ARW]) * $signed({1'b0, va_rdata[ARW-1:0]});
			mem_area_q <= va_rdata[ARW-1:0];
		end
		if (state_q == ST_FSUM && !div_go) begin
			res_q <= '0;
		end else if (state_q == ST_DIV && div_sts.done) begin
			res_q <= div_quot;
		end
		if (state_q == ST_LOAD && load_ok) begin
			result_index_q <= open_current_q;
			smoothed_q     <= res_q;
		end
	end

	// Control state: sequencer, open record, running sums, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			open_current_q <= '0;
			cur_slot_q     <= '0;
			ref_slot_q     <= '0;
			run_w_q        <= '0;
			run_a_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Open a record: take the new indexes and restart the sums.
			if (state_q == ST_RED && slot_sts.done && op_q == idwa_pkg::OP_START) begin
				open_current_q <= pidx_q;
				cur_slot_q     <= slot_a;
				ref_slot_q     <= slot_b;
				run_w_q        <= '0;
				run_a_q        <= '0;
			end
			// Advance the running sums by one member.
			if (state_q == ST_ACC) begin
				if (op_q == idwa_pkg::OP_REMOVE) begin
					run_w_q <= run_w_q - {{(WW-PW){prod_q[PW-1]}}, prod_q};
					run_a_q <= run_a_q - {{(SW-ARW){1'b0}}, mem_area_q};
				end else begin
					run_w_q <= run_w_q + {{(WW-PW){prod_q[PW-1]}}, prod_q};
					run_a_q <= run_a_q + {{(SW-ARW){1'b0}}, mem_area_q};
				end
			end
			// Hand the result to the output register and drop the sums.
			if (state_q == ST_LOAD && load_ok) begin
				result_valid_q <= 1'b1;
				run_w_q        <= '0;
				run_a_q        <= '0;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign result_index   = result_index_q;
	assign smoothed_value = smoothed_q;

	// The reduction unit is free whenever a new item transfers.
	`IDWA_ASSERT_IMP(a_slot_free_on_accept, clk, arst_n, item_accept, !slot_sts.busy)
	// The divider is never restarted while it works.
	`IDWA_ASSERT_IMP(a_div_free_on_start, clk, arst_n, div_start, !div_sts.busy)
	// Divider completion only arrives while the sequencer waits for it.
	`IDWA_ASSERT_IMP(a_div_done_in_wait, clk, arst_n, div_sts.done, state_q == ST_DIV)
	// A pending stalled result is never overwritten by the next record.
	`IDWA_ASSERT_NXT(a_hold_while_full, clk, arst_n,
		state_q == ST_LOAD && result_valid_q && result_stall, state_q == ST_LOAD)

endmodule

@@ tb/sv/incremental_disc_weighted_average_tb.sv @@
// Self-checking testbench for incremental_disc_weighted_average: directed corners,
// mixed record traffic and an output hold-off.
// Depends on idwa_pkg and the core RTL only.
module incremental_disc_weighted_average_tb;
	import idwa_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 90;   // margin for a record still closing
	localparam int LONG_HOLD    = 400;
	localparam int MIXED_ITEMS  = 400;  // per idle mix, four mixes

	typedef struct packed {
		opcode_t                 op;
		logic [IDX_W-1:0]        pidx;
		logic [IDX_W-1:0]        ridx;
		logic signed [VAL_W-1:0] value;
		logic [AREA_W-1:0]       area;
		logic                    eor;
	} disc_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
	} avg_result_t;

	// Tracks point values, areas and window sums exactly as the block should, and holds
	// the smoothed averages still owed by the block, oldest first.
	class disc_average_tracker;
		logic signed [VAL_W-1:0] point_value [4096];
		logic [AREA_W-1:0]       point_area [4096];
		logic [WSUM_W-1:0]       window_wsum [4096];
		logic [ASUM_W-1:0]       window_asum [4096];
		bit                      point_loaded [4096];
		bit                      point_summed [4096];
		int                      loaded_pts[$];
		int                      summed_pts[$];
		logic [IDX_W-1:0]        open_point;
		logic [IDX_W-1:0]        open_refpt;
		logic [WSUM_W-1:0]       run_wsum;
		logic [ASUM_W-1:0]       run_asum;
		avg_result_t             expected_averages[$];
		int                      mismatches;
		int                      checked;
		int                      saturated;
		int                      zeroed;

		function new();
			open_point = '0;
			open_refpt = '0;
			run_wsum = '0;
			run_asum = '0;
			mismatches = 0;
			checked = 0;
			saturated = 0;
			zeroed = 0;
		endfunction

		function int pending();
			return expected_averages.size();
		endfunction

		function void accumulate(int idx, bit remove);
			longint prod;
			prod = longint'(point_value[idx]) * longint'(point_area[idx]);
			if (remove) begin
				run_wsum = run_wsum - prod[WSUM_W-1:0];
				run_asum = run_asum - {{(ASUM_W-AREA_W){1'b0}}, point_area[idx]};
			end else begin
				run_wsum = run_wsum + prod[WSUM_W-1:0];
				run_asum = run_asum + {{(ASUM_W-AREA_W){1'b0}}, point_area[idx]};
			end
		endfunction

		function void note_item(disc_item_t it);
			logic [WSUM_W-1:0] wsum;
			logic [ASUM_W-1:0] asum;
			longint            wsum_s;
			longint            asum_s;
			longint            quot;
			avg_result_t       res;
			case (it.op)
				OP_LOAD: begin
					point_value[it.pidx] = it.value;
					point_area[it.pidx] = it.area;
					if (!point_loaded[it.pidx]) begin
						point_loaded[it.pidx] = 1'b1;
						loaded_pts.insert(loaded_pts.size(), int'(it.pidx));
					end
					return;
				end
				OP_START: begin
					open_point = it.pidx;
					open_refpt = it.ridx;
					run_wsum = '0;
					run_asum = '0;
				end
				OP_ADD:  accumulate(int'(it.pidx), 1'b0);
				default: accumulate(int'(it.pidx), 1'b1);
			endcase
			if (!it.eor)
				return;
			// Close the record: fold in the reference sums, store, divide.
			wsum = run_wsum;
			asum = run_asum;
			if (open_point != open_refpt) begin
				wsum = wsum + window_wsum[open_refpt];
				asum = asum + window_asum[open_refpt];
			end
			window_wsum[open_point] = wsum;
			window_asum[open_point] = asum;
			if (!point_summed[open_point]) begin
				point_summed[open_point] = 1'b1;
				summed_pts.insert(summed_pts.size(), int'(open_point));
			end
			wsum_s = longint'($signed(wsum));
			asum_s = longint'($signed(asum));
			quot = 0;
			if (asum_s > 0 && point_area[open_point] != 0) begin
				quot = wsum_s / asum_s;
				if (quot > longint'($signed(VAL_MAX))) begin
					quot = longint'($signed(VAL_MAX));
					saturated++;
				end else if (quot < longint'($signed(VAL_MIN))) begin
					quot = longint'($signed(VAL_MIN));
					saturated++;
				end
			end else begin
				zeroed++;
			end
			res.index = open_point;
			res.value = quot[VAL_W-1:0];
			expected_averages.insert(expected_averages.size(), res);
			run_wsum = '0;
			run_asum = '0;
		endfunction

		function void report(string field, longint want, longint got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_result(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val);
			avg_result_t want;
			if (expected_averages.size() == 0) begin
				report("unexpected result, smoothed_value", 0, longint'(val));
				return;
			end
			want = expected_averages.pop_front();
			checked++;
			if (idx !== want.index)
				report("result_index", longint'(want.index), longint'(idx));
			if (val !== want.value)
				report("smoothed_value", longint'(want.value), longint'(val));
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    item_valid;
	logic                    item_stall;
	logic [1:0]              opcode;
	logic [IDX_W-1:0]        point_index;
	logic [IDX_W-1:0]        reference_index;
	logic signed [VAL_W-1:0] sample_value;
	logic [AREA_W-1:0]       cell_area;
	logic                    end_of_record;
	logic                    result_valid;
	logic                    result_stall;
	logic [IDX_W-1:0]        result_index;
	logic signed [VAL_W-1:0] smoothed_value;

	disc_average_tracker tracker = new();
	int  items_sent = 0;
	int  cycle_count = 0;
	int  tx_max = 0;          // longest sender gap per item
	int  rx_max = 0;          // longest receiver stall per result
	bit  rx_hold_request = 1'b0;

	incremental_disc_weighted_average DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.opcode          (opcode),
		.point_index     (point_index),
		.reference_index (reference_index),
		.sample_value    (sample_value),
		.cell_area       (cell_area),
		.end_of_record   (end_of_record),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result_index    (result_index),
		.smoothed_value  (smoothed_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Sample both channels at the rising edge: note every accepted input
	// transfer first, then check every accepted result transfer.
	always @(posedge clk) begin
		disc_item_t seen;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				seen.op = opcode;
				seen.pidx = point_index;
				seen.ridx = reference_index;
				seen.value = sample_value;
				seen.area = cell_area;
				seen.eor = end_of_record;
				tracker.note_item(seen);
			end
			if (result_valid && !result_stall)
				tracker.check_result(result_index, smoothed_value);
		end
	end

	// Receiver: before each result draw a stall length and hold stall that
	// long, then release it and wait for the transfer. On request, hold off
	// for a long stretch so the output register and the core back up.
	initial begin
		int n;
		result_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_request) begin
				n = LONG_HOLD;
				rx_hold_request = 1'b0;
			end else begin
				n = $urandom_range(0, rx_max);
			end
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after the
	// transfer. Drop valid for the drawn gap, then offer the item and hold it.
	task automatic send_item(disc_item_t it);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode <= it.op;
		point_index <= it.pidx;
		reference_index <= it.ridx;
		sample_value <= it.value;
		cell_area <= it.area;
		end_of_record <= it.eor;
		item_valid <= 1'b1;
		do @(posedge clk); while (!(item_valid && !item_stall));
		items_sent++;
		@(negedge clk);
	endtask

	// Fields an opcode does not use get random content.
	function automatic disc_item_t noisy_item(opcode_t op, int pidx, bit eor);
		disc_item_t it;
		it.op = op;
		it.pidx = IDX_W'(pidx);
		it.ridx = IDX_W'($urandom);
		it.value = VAL_W'($urandom);
		it.area = AREA_W'($urandom);
		it.eor = eor;
		return it;
	endfunction

	task automatic send_load(int idx, logic signed [VAL_W-1:0] v, logic [AREA_W-1:0] a, bit eor);
		disc_item_t it;
		it = noisy_item(OP_LOAD, idx, eor);
		it.value = v;
		it.area = a;
		send_item(it);
	endtask

	task automatic send_start(int cur, int refpt, bit eor);
		disc_item_t it;
		it = noisy_item(OP_START, cur, eor);
		it.ridx = IDX_W'(refpt);
		send_item(it);
	endtask

	task automatic send_member(bit remove, int idx, bit eor);
		send_item(noisy_item(remove ? OP_REMOVE : OP_ADD, idx, eor));
	endtask

	// Drop valid and wait until every owed average has come back, plus the
	// latency of a record still closing.
	task automatic settle();
		item_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0:       return VAL_MAX;
			1:       return VAL_MIN;
			2:       return '0;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [AREA_W-1:0] rand_area();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return AREA_W'($urandom);
		endcase
	endfunction

	function automatic int pick_loaded();
		return tracker.loaded_pts[$urandom_range(0, tracker.loaded_pts.size() - 1)];
	endfunction

	// A reference is either the current point or one whose sums are stored.
	function automatic int pick_reference(int cur);
		if (tracker.summed_pts.size() == 0 || $urandom_range(0, 3) == 0)
			return cur;
		return tracker.summed_pts[$urandom_range(0, tracker.summed_pts.size() - 1)];
	endfunction

	task automatic send_random_record(bit complete);
		int cur;
		int members;
		cur = pick_loaded();
		members = $urandom_range(0, 8);
		send_start(cur, pick_reference(cur), complete && members == 0);
		for (int m = 0; m < members; m++)
			send_member($urandom_range(0, 9) < 3, pick_loaded(), complete && m == members - 1);
	endtask

	// Mostly complete records with random content; the rest reloads, stray
	// members and records left open.
	task automatic run_mixed(int count);
		int goal;
		int sel;
		goal = items_sent + count;
		while (items_sent < goal) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				send_load($urandom_range(0, 1) ? pick_loaded() : $urandom_range(0, 4095),
					rand_value(), rand_area(), 1'($urandom_range(0, 1)));
			else if (sel < 14)
				send_member(1'($urandom_range(0, 1)), pick_loaded(),
					1'($urandom_range(0, 1)));
			else if (sel < 18)
				send_random_record(1'b0);
			else
				send_random_record(1'b1);
		end
	endtask

	task automatic run_directed();
		send_load(0, VAL_MAX, 16'hFFFF, 1'b1);     // end mark on a load does nothing
		send_load(4095, VAL_MIN, 16'hFFFE, 1'b0);
		send_load(1, '0, '0, 1'b0);
		send_load(2, -24'sd1, 16'd1, 1'b0);
		send_load(3, 24'sd4096, 16'd300, 1'b0);
		send_load(5, VAL_MAX, 16'hFFFD, 1'b0);
		// members with no record open belong to point 0
		send_member(1'b0, 0, 1'b0);
		send_member(1'b1, 3, 1'b1);
		// more members after a closed record close it again
		send_member(1'b0, 2, 1'b1);
		// empty record closes at once with no area
		send_start(4095, 4095, 1'b1);
		// reference sums folded in
		send_start(3, 0, 1'b0);
		send_member(1'b0, 4095, 1'b0);
		send_member(1'b0, 0, 1'b0);
		send_member(1'b1, 4095, 1'b1);
		// current point with zero own area
		send_start(1, 3, 1'b0);
		send_member(1'b0, 0, 1'b1);
		// area sum of one against a huge weighted sum: saturate high, then low
		send_start(2, 2, 1'b0);
		send_member(1'b0, 0, 1'b0);
		send_member(1'b1, 4095, 1'b1);
		send_start(3, 3, 1'b0);
		send_member(1'b0, 4095, 1'b0);
		send_member(1'b1, 5, 1'b1);
		// negative area sum
		send_start(3, 2, 1'b0);
		send_member(1'b1, 0, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		opcode = OP_LOAD;
		point_index = '0;
		reference_index = '0;
		sample_value = '0;
		cell_area = '0;
		end_of_record = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_max = 3;
		rx_max = 3;
		run_directed();
		settle();

		// Idle mixes: both sides idling, no idling with a long output hold-off,
		// receiver idling only, sender idling only.
		tx_max = 13;
		rx_max = 13;
		run_mixed(MIXED_ITEMS);
		settle();
		tx_max = 0;
		rx_max = 0;
		rx_hold_request = 1'b1;
		run_mixed(MIXED_ITEMS);
		settle();
		tx_max = 0;
		rx_max = 13;
		run_mixed(MIXED_ITEMS);
		settle();
		tx_max = 13;
		rx_max = 0;
		run_mixed(MIXED_ITEMS);
		settle();

		$display("covered %0d input transfers and %0d checked averages, %0d saturated, %0d zero",
			items_sent, tracker.checked, tracker.saturated, tracker.zeroed);
		$display("covered directed corners, four idle mixes and a %0d-cycle hold-off",
			LONG_HOLD);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ incremental_disc_weighted_average.f @@
+incdir+rtl/core
rtl/core/idwa_pkg.sv
rtl/core/idwa_ram.sv
rtl/core/idwa_slot.sv
rtl/core/idwa_div.sv
rtl/core/incremental_disc_weighted_average.sv
tb/sv/incremental_disc_weighted_average_tb.sv
